@@ sv/timed_action_command_queue_core_defines.svh @@
// Assertion macros shared by the command queue modules.
`ifndef TIMED_ACTION_COMMAND_QUEUE_CORE_DEFINES_SVH
`define TIMED_ACTION_COMMAND_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTH
`define TACQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TACQ_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TACQ_ASSERT(lbl, prop, msg)
`define TACQ_NEVER(lbl, expr, msg)
`endif
`endif

@@ sv/tacq_pkg.sv @@
// Types and constants shared by the timed action command queue.
`timescale 1ns / 1ps

package tacq_pkg;

	// Default number of queue slots; the queue holds one command less.
	localparam int QUEUE_SLOTS_DEF = 16;

	// Action codes.
	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_POLL    = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;
	localparam logic [1:0] ACT_NONE    = 2'd3;

	// Command type that starts a timed wait when released.
	localparam logic [2:0] CMD_WAIT = 3'd0;

	// One input request.
	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         cmd_type;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic [31:0]        now_ms;
		logic               left_arm_busy;
		logic               right_arm_busy;
		logic               head_busy;
	} req_t;

	// One result.
	typedef struct packed {
		logic               dispatched;
		logic [2:0]         out_type;
		logic signed [31:0] out_a;
		logic signed [31:0] out_b;
		logic signed [31:0] out_c;
		logic               queue_empty;
		logic               overflow;
	} rsp_t;

	// One stored command.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] first;
		logic [31:0] second;
		logic [31:0] third;
	} slot_t;

	// Controller states.
	typedef enum logic [0:0] {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

@@ sv/tacq_ctrl.sv @@
// Controller state machine: request capture, commit and result handshake.
`timescale 1ns / 1ps
`include "timed_action_command_queue_core_defines.svh"

module tacq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tacq_pkg::cmd_t cmd
);

	tacq_pkg::state_t state_q;
	tacq_pkg::state_t state_next;
	logic             rsp_valid_q;
	logic             rsp_free;

	// The result register can take a new value when empty or being drained.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tacq_pkg::S_IDLE: begin
				if (req_valid) state_next = tacq_pkg::S_EXEC;
			end
			tacq_pkg::S_EXEC: begin
				if (rsp_free) state_next = tacq_pkg::S_IDLE;
			end
			default: state_next = tacq_pkg::S_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			tacq_pkg::S_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			tacq_pkg::S_EXEC: begin
				cmd.commit = rsp_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tacq_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// The result is valid from its commit until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// A captured request is always executed in the following cycle or later.
	`TACQ_ASSERT(a_capture_exec, cmd.capture |=> state_q == tacq_pkg::S_EXEC, "capture lost")
	// A commit never overwrites a result that is still stalled.
	`TACQ_NEVER(a_no_overwrite, cmd.commit && rsp_valid_q && rsp_stall, "result overwritten")
	// Every commit presents a result in the next cycle.
	`TACQ_ASSERT(a_commit_valid, cmd.commit |=> rsp_valid_q, "result not shown")

endmodule

@@ sv/tacq_dp.sv @@
// Datapath: slot memory, ring pointers, wait timer and result register.
`timescale 1ns / 1ps
`include "timed_action_command_queue_core_defines.svh"

module tacq_dp #(
	parameter int QUEUE_SLOTS = tacq_pkg::QUEUE_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tacq_pkg::cmd_t cmd,
	input  tacq_pkg::req_t req,
	output tacq_pkg::rsp_t rsp
);

	localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

	tacq_pkg::req_t req_q;
	tacq_pkg::slot_t mem_q [QUEUE_SLOTS];
	tacq_pkg::slot_t rd_q;
	tacq_pkg::rsp_t rsp_q;
	tacq_pkg::rsp_t rsp_next;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_inc;
	logic [PTR_W-1:0] wp_inc;
	logic [PTR_W-1:0] rp_new;
	logic [PTR_W-1:0] wp_new;
	logic [31:0]      wait_start_q;
	logic [31:0]      wait_length_q;
	logic             wait_active_q;
	logic [31:0]      elapsed;
	logic             waiting;
	logic             busy;
	logic             empty;
	logic             full;
	logic             do_enq;
	logic             do_send;
	logic             is_clear;

	// Ring pointer increments wrap at the last slot.
	assign rp_inc = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign wp_inc = (wp_q == LAST) ? '0 : wp_q + 1'b1;

	// Queue state and dispatch conditions for the request in hand.
	assign empty    = (rp_q == wp_q);
	assign full     = (wp_inc == rp_q);
	assign busy     = req_q.left_arm_busy | req_q.right_arm_busy | req_q.head_busy;
	assign elapsed  = req_q.now_ms - wait_start_q;
	assign waiting  = wait_active_q && (elapsed < wait_length_q);
	assign do_enq   = (req_q.action == tacq_pkg::ACT_ENQUEUE) && !full;
	assign do_send  = (req_q.action == tacq_pkg::ACT_POLL) && !empty && !busy && !waiting;
	assign is_clear = (req_q.action == tacq_pkg::ACT_CLEAR);

	// Pointers after the request and the result that goes with it.
	always_comb begin
		rp_new = rp_q;
		wp_new = wp_q;
		if (is_clear) begin
			rp_new = LAST;
			wp_new = LAST;
		end else if (do_enq) begin
			wp_new = wp_inc;
		end else if (do_send) begin
			rp_new = rp_inc;
		end
		rsp_next.dispatched  = do_send;
		rsp_next.out_type    = do_send ? rd_q.kind : 3'd0;
		rsp_next.out_a       = do_send ? rd_q.first : 32'sd0;
		rsp_next.out_b       = do_send ? rd_q.second : 32'sd0;
		rsp_next.out_c       = do_send ? rd_q.third : 32'sd0;
		rsp_next.queue_empty = (rp_new == wp_new);
		rsp_next.overflow    = (req_q.action == tacq_pkg::ACT_ENQUEUE) && full;
	end

	// Request register, loaded when the controller accepts a request.
	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	// Slot memory: written at the tail, read at the head's next slot every cycle.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_enq) begin
			mem_q[wp_inc] <= '{kind: req_q.cmd_type, first: req_q.value_a,
				second: req_q.value_b, third: req_q.value_c};
		end
		rd_q <= mem_q[rp_inc];
	end

	// Pointers and wait timer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q          <= LAST;
			wp_q          <= LAST;
			wait_start_q  <= '0;
			wait_length_q <= '0;
			wait_active_q <= 1'b0;
		end else if (cmd.commit) begin
			rp_q <= rp_new;
			wp_q <= wp_new;
			if (do_send) begin
				wait_active_q <= (rd_q.kind == tacq_pkg::CMD_WAIT);
				if (rd_q.kind == tacq_pkg::CMD_WAIT) begin
					wait_start_q  <= req_q.now_ms;
					wait_length_q <= rd_q.first;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) rsp_q <= rsp_next;
	end

	assign rsp = rsp_q;

	// Pointers never leave the slot range.
	`TACQ_NEVER(a_ptr_range, (rp_q > LAST) || (wp_q > LAST), "pointer out of range")
	// A committed clear leaves the queue empty.
	`TACQ_ASSERT(a_clear_empty, cmd.commit && is_clear |=> rp_q == wp_q, "clear not empty")
	// A refused enqueue leaves the tail where it was.
	`TACQ_ASSERT(a_ovf_hold, cmd.commit && rsp_next.overflow |=> $stable(wp_q), "tail moved")

endmodule

@@ sv/timed_action_command_queue_core.sv @@
// Top level of the timed action command queue: controller and datapath.
//
// Usage: each request on the req channel carries an action (enqueue, poll,
// clear), a command type with three values, the current millisecond time
// and three actuator busy flags. Every request yields exactly one result on
// the rsp channel: the released command on a successful poll, the queue
// empty flag after the request, and an overflow flag for a refused enqueue.
// A request is taken at an edge where req_valid is high and req_stall low.
// The request is registered when taken; the controller then commits it in
// its execute state, loading the result register, and holds the commit
// while that register still has a stalled result. A new request is taken
// only in the idle state, so not before the last request is committed.
// The block takes a new request while an earlier result still waits; the
// commit of that request holds until the result register is free, so a
// stalled receiver stalls the request side after one more request.
// Reset: both ring pointers go to the last slot (queue empty), the wait
// timer is cleared and no result is valid. Slot contents stay undefined
// until written and need no clearing pass.
`timescale 1ns / 1ps

module timed_action_command_queue_core #(
	parameter int QUEUE_SLOTS = tacq_pkg::QUEUE_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tacq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tacq_pkg::rsp_t rsp
);

	tacq_pkg::cmd_t cmd;

	// Controller.
	tacq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Datapath.
	tacq_dp #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
